>>> rtl/multiplexed_servo_pulse_generator_macros.svh
// Assertion macros for the multiplexed servo pulse generator.
// Included by the top level; needs no other file.
`ifndef MULTIPLEXED_SERVO_PULSE_GENERATOR_MACROS_SVH
`define MULTIPLEXED_SERVO_PULSE_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mspg_pkg.sv
// Shared types and constants for the multiplexed servo pulse generator.
// No dependencies.
`default_nettype none
package mspg_pkg;

	localparam int SERVO_COUNT_DEF = 4;
	localparam int PIN_COUNT       = 4;

	localparam logic [15:0] STOP_WIDTH_TICKS = 16'd937;
	localparam logic [15:0] PERIOD_RESET     = 16'd12499;
	localparam logic [15:0] SLOT_RESET       = 16'd3125;

	// Item function codes
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_PERIOD_LAST_TICK = 1'b0,
		CFG_SLOT_WIDTH_TICKS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic        func;
		logic [1:0]  servo_index;
		logic [15:0] width_ticks;
	} cmd_t;

	typedef struct packed {
		logic [PIN_COUNT-1:0] servo_pins;
		logic                 edge_event;
	} rsp_t;

	typedef struct packed {
		logic [15:0] period_last_tick;
		logic [15:0] slot_width_ticks;
	} cfg_t;

endpackage
`default_nettype wire

>>> rtl/mspg_core.sv
// Slot timer, compare logic, pulse width store and pin levels.
// Depends on mspg_pkg.
`default_nettype none
module mspg_core
	import mspg_pkg::*;
#(
	parameter int SERVO_COUNT = SERVO_COUNT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire cmd_t item,
	input  wire cfg_t cfg,
	output rsp_t      res
);

	localparam int AW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

	logic [15:0]          timer_q;
	logic [15:0]          compare_q;
	logic [AW-1:0]        active_q;
	logic                 rising_q;
	logic [15:0]          widths_q [SERVO_COUNT];
	logic [PIN_COUNT-1:0] pins_q;

	logic [15:0]          timer_d;
	logic [15:0]          compare_d;
	logic [AW-1:0]        active_d;
	logic                 rising_d;
	logic [PIN_COUNT-1:0] pins_d;
	logic                 edge_d;
	logic [AW-1:0]        cur;
	logic [AW:0]          nxt_slot;
	logic [16+AW:0]       slot_start;
	logic                 is_tick;
	logic                 match;

	assign is_tick    = (item.func == FUNC_TICK);
	assign cur        = (32'(active_q) >= SERVO_COUNT) ? '0 : active_q;
	assign nxt_slot   = {1'b0, cur} + {{AW{1'b0}}, 1'b1};
	assign slot_start = cfg.slot_width_ticks * nxt_slot;
	assign match      = is_tick && (timer_q == compare_q);

	always_comb begin
		timer_d   = timer_q;
		compare_d = compare_q;
		active_d  = active_q;
		rising_d  = rising_q;
		pins_d    = pins_q;
		edge_d    = 1'b0;
		if (match) begin
			edge_d = 1'b1;
			for (int p = 0; p < PIN_COUNT; p++) begin
				if (32'(cur) == p) begin
					pins_d[p] = rising_q;
				end
			end
			if (rising_q) begin
				compare_d = compare_q + widths_q[cur];
				rising_d  = 1'b0;
			end else begin
				if (32'(cur) == SERVO_COUNT - 1) begin
					compare_d = '0;
					active_d  = '0;
				end else begin
					compare_d = slot_start[15:0];
					active_d  = nxt_slot[AW-1:0];
				end
				rising_d = 1'b1;
			end
		end
		if (is_tick) begin
			timer_d = (timer_q == cfg.period_last_tick) ? '0 : timer_q + 16'd1;
		end
	end

	assign res.servo_pins = pins_d;
	assign res.edge_event = edge_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q   <= '0;
			compare_q <= '0;
			active_q  <= '0;
			rising_q  <= 1'b1;
			pins_q    <= '0;
			for (int i = 0; i < SERVO_COUNT; i++) begin
				widths_q[i] <= STOP_WIDTH_TICKS;
			end
		end else if (en) begin
			timer_q   <= timer_d;
			compare_q <= compare_d;
			active_q  <= active_d;
			rising_q  <= rising_d;
			pins_q    <= pins_d;
			// width writes take hold at the servo's next rising match
			if (item.func == FUNC_WRITE) begin
				for (int i = 0; i < SERVO_COUNT; i++) begin
					if (32'(item.servo_index) == i) begin
						widths_q[i] <= item.width_ticks;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/multiplexed_servo_pulse_generator.sv
// Multiplexed servo pulse generator: top level with handshake stages.
// Depends on mspg_pkg, mspg_core and the assertion macro header.
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one item per
//   transfer: a timer tick (func = tick) or a pulse width write for one
//   servo (func = write, servo_index, width_ticks).
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one item per
//   command item: the pin levels after that item and an edge flag set when
//   a compare match toggled a pin.
//   cfg port (cfg_we / cfg_index / cfg_data) writes the period and slot
//   width registers; write it only while no items are in flight.
// Path: an accepted item passes through the input register and then the
//   result register before it is presented on rsp.
// Throughput: one item per cycle while rsp_stall is low; one compare / add /
//   slot multiply pass sits between the input register and the result register.
// Reset (arst_n low): channels go empty, timer and compare clear, servo 0
//   is active awaiting its rising edge, all widths return to the stop
//   position, all pins low, registers return to their defaults.
// Stall: while rsp_stall holds, the result holds and the input register
//   keeps one more item; cmd_stall rises once both are full.
`default_nettype none
`include "multiplexed_servo_pulse_generator_macros.svh"
module multiplexed_servo_pulse_generator
	import mspg_pkg::*;
#(
	parameter int SERVO_COUNT = SERVO_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire cmd_t        cmd,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp
);

	cfg_t cfg_q;
	logic valid_s1;
	cmd_t item_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t res;
	logic adv;
	logic cmd_take;

	// Result register can load when empty or being taken this cycle.
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !adv;
	assign cmd_take  = cmd_valid && !cmd_stall;

	// Configuration registers: plain writes, unknown indexes do nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_last_tick <= PERIOD_RESET;
			cfg_q.slot_width_ticks <= SLOT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PERIOD_LAST_TICK: cfg_q.period_last_tick <= cfg_data;
				CFG_SLOT_WIDTH_TICKS: cfg_q.slot_width_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: hold the item until the result register takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			item_s1 <= cmd;
		end
	end

	// State update and result in one pass, committed as the item moves on.
	mspg_core #(
		.SERVO_COUNT(SERVO_COUNT)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (valid_s1 && adv),
		.item  (item_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`MSPG_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, cmd_stall, valid_s1 && rsp_valid_q, "cmd stalled with a free stage")
	`MSPG_ASSERT_NEXT(a_item_reaches_rsp, clk, arst_n, valid_s1 && adv, rsp_valid, "item lost between stages")
	`MSPG_ASSERT_NEXT(a_write_no_edge, clk, arst_n, valid_s1 && adv && (item_s1.func == FUNC_WRITE), !rsp.edge_event, "width write flagged an edge")

endmodule
`default_nettype wire
